// File: src/ipc_pkg.sv
package ipc_pkg;

  // Field and state widths
  localparam int DATA_W = 16;
  localparam int ERR_W  = 17;
  localparam int CTRL_W = 18;
  // Gain (unsigned 16 bit, one sign bit added) times error (17 bit signed)
  localparam int PROD_W = 34;
  // Accumulator: wide enough for every sum at any supported fraction width
  localparam int ACC_W  = 40;

  localparam int FRAC_BITS_DEF = 14;

  localparam int CFG_IDX_W = 2;

  localparam logic [DATA_W-1:0] GAIN_A_RST        = 16'd13107;
  localparam logic [DATA_W-1:0] GAIN_B_RST        = 16'd13104;
  localparam logic [DATA_W-1:0] TORQUE_OFFSET_RST = 16'd1802;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_A        = 2'd0,
    CFG_GAIN_B        = 2'd1,
    CFG_TORQUE_OFFSET = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic        [DATA_W-1:0] gain_a;
    logic        [DATA_W-1:0] gain_b;
    logic signed [DATA_W-1:0] torque_offset;
  } ipc_cfg_t;

endpackage

// File: src/ipc_cfg_regs.sv
module ipc_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ipc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ipc_pkg::DATA_W-1:0]      cfg_data,
  output ipc_pkg::ipc_cfg_t               cfg
);

  ipc_pkg::ipc_cfg_t cfg_r;
  ipc_pkg::ipc_cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        ipc_pkg::CFG_GAIN_A:        cfg_nxt.gain_a        = cfg_data;
        ipc_pkg::CFG_GAIN_B:        cfg_nxt.gain_b        = cfg_data;
        ipc_pkg::CFG_TORQUE_OFFSET: cfg_nxt.torque_offset = $signed(cfg_data);
        default:                    cfg_nxt               = cfg_r; // drop
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_a        <= ipc_pkg::GAIN_A_RST;
      cfg_r.gain_b        <= ipc_pkg::GAIN_B_RST;
      cfg_r.torque_offset <= $signed(ipc_pkg::TORQUE_OFFSET_RST);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: src/ipc_core.sv
module ipc_core #(
  parameter int FRAC_BITS = ipc_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  logic [ipc_pkg::DATA_W-1:0] target_pos,
  input  logic [ipc_pkg::DATA_W-1:0] measured_pos,
  input  ipc_pkg::ipc_cfg_t          cfg,
  output logic [ipc_pkg::DATA_W-1:0] duty,
  output logic                       clamped
);

  localparam int AW = ipc_pkg::ACC_W;
  localparam logic signed [AW-1:0] ONE_V = AW'(1) << FRAC_BITS;

  logic signed [ipc_pkg::ERR_W-1:0]  prev_error_r;
  logic signed [ipc_pkg::CTRL_W-1:0] prev_control_r;

  logic signed [ipc_pkg::ERR_W-1:0]  err;
  logic signed [ipc_pkg::PROD_W-1:0] prod_a;
  logic signed [ipc_pkg::PROD_W-1:0] prod_b;
  logic signed [AW-1:0]              term_a;
  logic signed [AW-1:0]              term_b;
  logic signed [AW-1:0]              offs;
  logic signed [AW-1:0]              ctrl;
  logic signed [AW-1:0]              res;
  logic signed [AW-1:0]              res_fin;
  logic signed [AW-1:0]              ctrl_fin;

  assign err = $signed({1'b0, target_pos}) - $signed({1'b0, measured_pos});

  // Two independent products, truncated toward minus infinity
  assign prod_a = $signed({1'b0, cfg.gain_a}) * err;
  assign prod_b = $signed({1'b0, cfg.gain_b}) * prev_error_r;
  assign term_a = AW'(prod_a >>> FRAC_BITS);
  assign term_b = AW'(prod_b >>> FRAC_BITS);
  assign offs   = AW'(cfg.torque_offset);

  assign ctrl = AW'(prev_control_r) - term_b + term_a;
  assign res  = ctrl + offs;

  // Saturate and back-compute the stored control to stop windup
  always_comb begin
    res_fin  = res;
    ctrl_fin = ctrl;
    clamped  = 1'b0;
    unique if (res > ONE_V) begin
      res_fin  = ONE_V;
      ctrl_fin = ONE_V - offs;
      clamped  = 1'b1;
    end else if (res < -ONE_V) begin
      res_fin  = -ONE_V;
      ctrl_fin = -ONE_V - offs;
      clamped  = 1'b1;
    end else begin
      res_fin  = res;
      ctrl_fin = ctrl;
      clamped  = 1'b0;
    end
  end

  assign duty = res_fin[ipc_pkg::DATA_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_error_r   <= '0;
      prev_control_r <= '0;
    end else if (step) begin
      prev_error_r   <= err;
      prev_control_r <= ctrl_fin[ipc_pkg::CTRL_W-1:0];
    end
  end

endmodule

// File: src/incremental_pi_controller.sv
// Channel  Direction  Ports                                 Payload
// -------  ---------  ------------------------------------  ---------------------------------
// in       slave      in_tvalid  in_tready  in_tdata        target_pos, measured_pos
// out      master     out_tvalid out_tready out_tdata/tuser duty / clamped
// cfg      slave      cfg_valid  cfg_ready  cfg_index/data  gain_a, gain_b, torque_offset
//
// One item per cycle sustained while the receiver keeps out_tready high; an
// item goes through the input register, then the result register, before it
// shows on out_tvalid and can be taken.
// The only loop is prev_error/prev_control, closed through one pass of two
// 17x17 multipliers, an adder chain and the clamp, all combinational.
// Reset (rst_n, synchronous, active low) empties both stages, clears the
// controller state and loads the default gains and offset.
// A stalled output holds its item; the input register still advances into the
// result register the same cycle that the result is taken.
module incremental_pi_controller #(
  parameter int FRAC_BITS = ipc_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input item
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [2*ipc_pkg::DATA_W-1:0]    in_tdata,   // [15:0] target_pos, [31:16] measured_pos
  // result item
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [ipc_pkg::DATA_W-1:0]      out_tdata,  // [15:0] duty
  output logic                            out_tuser,  // [0] clamped
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ipc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ipc_pkg::DATA_W-1:0]      cfg_data
);

  localparam int DW = ipc_pkg::DATA_W;

  ipc_pkg::ipc_cfg_t cfg;

  // Input stage
  logic          in_vld_r;
  logic [DW-1:0] tgt_r;
  logic [DW-1:0] meas_r;

  // Result stage
  logic          out_vld_r;
  logic [DW-1:0] duty_r;
  logic          clamped_r;

  logic          advance;
  logic          in_fire;
  logic [DW-1:0] duty_c;
  logic          clamped_c;

  // Move the input item into the result register when that register is free
  // or is being emptied this cycle; the controller state updates with it.
  assign advance   = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  assign out_tvalid = out_vld_r;
  assign out_tdata  = duty_r;
  assign out_tuser  = clamped_r;

  ipc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ipc_core #(
    .FRAC_BITS (FRAC_BITS)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (advance),
    .target_pos   (tgt_r),
    .measured_pos (meas_r),
    .cfg          (cfg),
    .duty         (duty_c),
    .clamped      (clamped_c)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      tgt_r  <= in_tdata[DW-1:0];
      meas_r <= in_tdata[2*DW-1:DW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      duty_r    <= duty_c;
      clamped_r <= clamped_c;
    end
  end

endmodule

// File: src/ipc_checker.sv
module ipc_checker #(
  parameter int FRAC_BITS = ipc_pkg::FRAC_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [ipc_pkg::DATA_W-1:0]    out_tdata,
  input logic                          out_tuser
);

  localparam int DW = ipc_pkg::DATA_W;
  localparam logic signed [DW-1:0] ONE_V = (FRAC_BITS <= DW - 2) ? DW'(1) << FRAC_BITS : '0;
  localparam bit EXACT = (FRAC_BITS <= DW - 2);

  // Duty stays inside the saturation limits
  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    (EXACT && out_tvalid) |->
      ($signed(out_tdata) <= ONE_V) && ($signed(out_tdata) >= -ONE_V))
    else $error("duty outside saturation limits");

  // A clamped result sits exactly on a limit
  a_clamp_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (EXACT && out_tvalid && out_tuser) |->
      ($signed(out_tdata) == ONE_V) || ($signed(out_tdata) == -ONE_V))
    else $error("clamped flag without duty on a limit");

  // Every accepted item shows a result once through the input and result registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> ##2 out_tvalid)
    else $error("result missing two cycles after accept");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind incremental_pi_controller ipc_checker #(.FRAC_BITS(FRAC_BITS)) u_ipc_checker (.*);

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import ipc_pkg::*;

  localparam int FRAC             = FRAC_BITS_DEF;
  localparam int PIPE_LAT         = 2;     // input register, then result register
  localparam int MAX_REPORTS      = 10;
  localparam int LONG_HOLD_CYCLES = 150;
  localparam int RAND_PER_PHASE   = 190;
  localparam int NUM_PHASES       = 7;
  localparam int RANDOM_PHASE     = 5;     // gains and offset drawn at random
  localparam int HOLD_PHASE       = 2;     // receiver holds off, sender keeps pushing
  localparam int PAUSE_PHASE      = 4;     // sender waits for every result mid-phase
  localparam int UNUSED_IDX_PHASE = 3;     // write to the unmapped register index first

  // Index 3 decodes to no register; a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  // Directed items, packed as on in_tdata: {measured_pos, target_pos}.
  localparam logic [31:0] DIRECTED [20] = '{
    32'h0000_0000, 32'h0000_FFFF, 32'h0000_FFFF, 32'hFFFF_0000, 32'hFFFF_0000,
    32'hFFFF_FFFF, 32'h4000_4000, 32'h4000_4010, 32'h4010_4000, 32'h7FFF_8000,
    32'h0000_0001, 32'h0001_0000, 32'hAAAA_5555, 32'h5555_AAAA, 32'h8000_8000,
    32'h1000_1200, 32'h1200_1000, 32'h3000_3000, 32'hFFFE_FFFF, 32'h0000_0000
  };

  // Per-phase settings: zero gains, full-scale gains, the offset at both
  // clamp levels and beyond them in both directions.
  localparam logic [DATA_W-1:0] PHASE_GAIN_A [NUM_PHASES] =
    '{16'd0, 16'd65535, 16'd16384, 16'd13107, 16'd65535, 16'd0, 16'd4096};
  localparam logic [DATA_W-1:0] PHASE_GAIN_B [NUM_PHASES] =
    '{16'd0, 16'd65535, 16'd8192, 16'd13104, 16'd0, 16'd0, 16'd4000};
  localparam logic [DATA_W-1:0] PHASE_OFFSET [NUM_PHASES] =
    '{16'h0000, 16'h4000, 16'hC000, 16'h7FFF, 16'h8000, 16'h0000, 16'd1802};

  typedef struct {
    logic [DATA_W-1:0] duty;
    logic              clamped;
  } pi_result_t;

  // Velocity-form PI predictor plus the queue of duty commands still owed.
  class pi_scoreboard;
    logic        [DATA_W-1:0] gain_a;
    logic        [DATA_W-1:0] gain_b;
    logic signed [DATA_W-1:0] torque_offset;
    logic signed [ERR_W-1:0]  last_error;
    logic signed [CTRL_W-1:0] last_control;
    pi_result_t               duty_q[$];
    int unsigned              mismatches;

    function new();
      gain_a        = GAIN_A_RST;
      gain_b        = GAIN_B_RST;
      torque_offset = TORQUE_OFFSET_RST;
      last_error    = '0;
      last_control  = '0;
      mismatches    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
      case (idx)
        CFG_GAIN_A:        gain_a = value;
        CFG_GAIN_B:        gain_b = value;
        CFG_TORQUE_OFFSET: torque_offset = value;
        default: ;
      endcase
    endfunction

    function void note_input(logic [DATA_W-1:0] tgt, logic [DATA_W-1:0] meas);
      longint     one, t, m, err, pe, ga, gb, offs, ctrl, sum;
      pi_result_t r;
      one  = longint'(1) << FRAC;
      t    = tgt;
      m    = meas;
      ga   = gain_a;
      gb   = gain_b;
      pe   = last_error;
      offs = torque_offset;
      err  = t - m;
      // >>> on a signed longint floors, matching the truncation in hardware
      ctrl = last_control - ((gb * pe) >>> FRAC) + ((ga * err) >>> FRAC);
      sum  = ctrl + offs;
      r.clamped = 1'b0;
      // On saturation, back-compute the stored control so it cannot wind up.
      if (sum > one) begin
        sum       = one;
        ctrl      = one - offs;
        r.clamped = 1'b1;
      end
      if (sum < -one) begin
        sum       = -one;
        ctrl      = -one - offs;
        r.clamped = 1'b1;
      end
      last_error   = err[ERR_W-1:0];
      last_control = ctrl[CTRL_W-1:0];
      r.duty       = sum[DATA_W-1:0];
      duty_q.push_back(r);
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("mismatch: %s", msg);
    endfunction

    function void check_result(logic [DATA_W-1:0] duty, logic clamped);
      pi_result_t want;
      if (duty_q.size() == 0) begin
        flag($sformatf("result with none pending: duty=%0d clamped=%0b",
                       $signed(duty), clamped));
        return;
      end
      want = duty_q.pop_front();
      if (duty !== want.duty)
        flag($sformatf("duty expected %0d got %0d", $signed(want.duty), $signed(duty)));
      if (clamped !== want.clamped)
        flag($sformatf("clamped expected %0b got %0b", want.clamped, clamped));
    endfunction

    function int pending();
      return duty_q.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [2*DATA_W-1:0]    in_tdata;   // [15:0] target_pos, [31:16] measured_pos
  logic                   out_tvalid;
  logic                   out_tready;
  logic [DATA_W-1:0]      out_tdata;  // [15:0] duty
  logic                   out_tuser;  // [0] clamped
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [DATA_W-1:0]      cfg_data;

  pi_scoreboard sb = new();
  bit           long_hold_req = 1'b0;

  incremental_pi_controller u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Sample every handshake on the rising edge. Check results before noting a
  // new item so a stray result can never pair with an expectation from the
  // same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
      if (in_tvalid && in_tready) sb.note_input(in_tdata[15:0], in_tdata[31:16]);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Mostly small errors around a random set point so the loop stays out of
  // saturation; the rest are full-range, rail-to-rail and zero-error items.
  function automatic void random_item(output logic [DATA_W-1:0] tgt,
                                      output logic [DATA_W-1:0] meas);
    int unsigned kind;
    int          t;
    kind = $urandom_range(0, 9);
    meas = DATA_W'($urandom);
    tgt  = DATA_W'($urandom);
    if (kind < 6) begin
      t = int'(meas) + int'($urandom_range(0, 600)) - 300;
      if (t < 0) t = 0;
      if (t > 65535) t = 65535;
      tgt = t[DATA_W-1:0];
    end else if (kind == 8) begin
      tgt  = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      meas = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    end else if (kind == 9) begin
      tgt = meas;
    end
  endfunction

  // Call at a falling edge; return at the falling edge after acceptance with
  // tvalid still high, so a following item goes out back to back.
  task automatic send_item(input logic [DATA_W-1:0] tgt, input logic [DATA_W-1:0] meas);
    in_tvalid <= 1'b1;
    in_tdata  <= {meas, tgt};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic source_gap(input int unsigned cycles);
    if (cycles != 0) begin
      in_tvalid <= 1'b0;
      repeat (cycles) @(negedge clk);
    end
  endtask

  // Leaves cfg_valid high; the caller drops it after the last write.
  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Hold the input idle until every owed result is back, then let the
  // pipeline settle.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (PIPE_LAT) @(negedge clk);
  endtask

  // Receiver: random back-pressure in stretches, plus one long hold on request.
  initial begin
    int unsigned hold_left;
    int unsigned cyc;
    bit          steady;
    hold_left = 0;
    cyc       = 0;
    steady    = 1'b1;
    out_tready <= 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 200 == 0) steady = ($urandom_range(0, 2) == 0);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LONG_HOLD_CYCLES;
      end
      if (hold_left == 0 && !steady && $urandom_range(0, 3) == 0) hold_left = pick_gap();
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Stimulus: reset, directed items at the reset gains, then one random
  // phase per register setting.
  initial begin
    logic [DATA_W-1:0] tgt, meas;
    logic [DATA_W-1:0] ga, gb, offs;
    int unsigned       ph, n, burst_left;
    bit                src_steady;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_GAIN_A;
    cfg_data  <= '0;
    rst_n     <= 1'b0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (DIRECTED[i]) begin
      send_item(DIRECTED[i][15:0], DIRECTED[i][31:16]);
      if (i % 3 == 2) source_gap(pick_gap());
    end

    burst_left = 0;
    src_steady = 1'b0;
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      drain_results();
      if (ph == UNUSED_IDX_PHASE) write_cfg(CFG_UNUSED_IDX, 16'hFFFF);
      ga   = PHASE_GAIN_A[ph];
      gb   = PHASE_GAIN_B[ph];
      offs = PHASE_OFFSET[ph];
      if (ph == RANDOM_PHASE) begin
        ga   = DATA_W'($urandom);
        gb   = DATA_W'($urandom);
        offs = DATA_W'($urandom_range(0, 32768) - 16384);
      end
      write_cfg(CFG_GAIN_A, ga);
      write_cfg(CFG_GAIN_B, gb);
      write_cfg(CFG_TORQUE_OFFSET, offs);
      cfg_valid <= 1'b0;

      for (n = 0; n < RAND_PER_PHASE; n++) begin
        if (n % 48 == 0) src_steady = ($urandom_range(0, 2) == 0);
        // Stall the receiver and keep pushing so the block backs up.
        if (ph == HOLD_PHASE && n == 40) begin
          long_hold_req = 1'b1;
          burst_left    = 30;
        end
        if (ph == PAUSE_PHASE && n == 90) drain_results();
        random_item(tgt, meas);
        send_item(tgt, meas);
        if (burst_left != 0) burst_left--;
        else if (!src_steady && $urandom_range(0, 2) == 0) source_gap(pick_gap());
      end
    end

    drain_results();
    repeat (PIPE_LAT + 8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin
    #1000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
